>>> rtl/i2cms_pkg.sv
// Shared codes, types and tables for the I2C master bit sequencer.
package i2cms_pkg;

	// command codes
	localparam logic [2:0] CMD_NONE  = 3'd0;
	localparam logic [2:0] CMD_START = 3'd1;
	localparam logic [2:0] CMD_STOP  = 3'd2;
	localparam logic [2:0] CMD_WRITE = 3'd3;
	localparam logic [2:0] CMD_READ  = 3'd4;
	localparam logic [2:0] CMD_WACK  = 3'd5;
	localparam logic [2:0] CMD_NACK  = 3'd6;

	// line level codes of a phase
	localparam logic [1:0] LV_LOW  = 2'd0;
	localparam logic [1:0] LV_HIGH = 2'd1;
	localparam logic [1:0] LV_KEEP = 2'd2;
	localparam logic [1:0] LV_BIT  = 2'd3;

	// phase kinds
	localparam logic [1:0] PH_DELAY = 2'd0;
	localparam logic [1:0] PH_TICK  = 2'd1;
	localparam logic [1:0] PH_POLL  = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_TPD  = 2'd0;
	localparam logic [1:0] CFG_POLL = 2'd1;

	localparam logic [9:0] TPD_RESET  = 10'd5;
	localparam logic [7:0] POLL_RESET = 8'd255;

	// write: three phases per bit over eight bits; read: sample/low pairs after step 0
	localparam logic [4:0] WR_BIT_STEPS = 5'd24;
	localparam logic [4:0] RD_BIT_LAST  = 5'd16;

	// step index modulo three
	localparam logic [1:0] MOD3_TBL [32] = '{
		2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1,
		2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0,
		2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2,
		2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1
	};

	typedef struct packed {
		logic [1:0] scl;
		logic [1:0] sda;
		logic [1:0] kind;
		logic       sample;
		logic       last;
	} phase_t;

	typedef struct packed {
		logic [9:0] ticks_per_delay;
		logic [7:0] ack_poll_limit;
	} cfg_t;

	typedef struct packed {
		logic       scl;
		logic       sda;
		logic       busy;
		logic       done;
		logic [7:0] rd_byte;
		logic       ack;
	} res_t;

endpackage

>>> rtl/i2cms_phase.sv
// Phase decoder: line levels, kind and flags of one step of a command.
module i2cms_phase (
	input  logic [2:0]      cmd,
	input  logic [4:0]      step,
	output i2cms_pkg::phase_t ph
);
	import i2cms_pkg::*;

	// look up the phase of this command step
	always_comb begin
		ph = '{scl: LV_HIGH, sda: LV_HIGH, kind: PH_DELAY, sample: 1'b0, last: 1'b0};
		case (cmd)
			CMD_START: begin
				if (step == 5'd0)
					ph = '{LV_HIGH, LV_HIGH, PH_DELAY, 1'b0, 1'b0};
				else if (step == 5'd1)
					ph = '{LV_KEEP, LV_LOW, PH_DELAY, 1'b0, 1'b0};
				else
					ph = '{LV_LOW, LV_KEEP, PH_TICK, 1'b0, 1'b1};
			end
			CMD_STOP: begin
				if (step == 5'd0)
					ph = '{LV_HIGH, LV_LOW, PH_DELAY, 1'b0, 1'b0};
				else if (step == 5'd1)
					ph = '{LV_KEEP, LV_HIGH, PH_DELAY, 1'b0, 1'b0};
				else
					ph = '{LV_LOW, LV_KEEP, PH_TICK, 1'b0, 1'b1};
			end
			CMD_WRITE: begin
				if (step < WR_BIT_STEPS) begin
					case (MOD3_TBL[step])
						2'd0:    ph = '{LV_LOW, LV_KEEP, PH_DELAY, 1'b0, 1'b0};
						2'd1:    ph = '{LV_KEEP, LV_BIT, PH_DELAY, 1'b0, 1'b0};
						default: ph = '{LV_HIGH, LV_KEEP, PH_DELAY, 1'b1, 1'b0};
					endcase
				end else if (step == WR_BIT_STEPS)
					ph = '{LV_LOW, LV_KEEP, PH_DELAY, 1'b0, 1'b0};
				else
					ph = '{LV_KEEP, LV_HIGH, PH_DELAY, 1'b0, 1'b1};
			end
			CMD_READ: begin
				if (step == 5'd0)
					ph = '{LV_LOW, LV_KEEP, PH_DELAY, 1'b0, 1'b0};
				else if (step <= RD_BIT_LAST) begin
					if (step[0])
						ph = '{LV_HIGH, LV_HIGH, PH_DELAY, 1'b1, 1'b0};
					else
						ph = '{LV_LOW, LV_KEEP, PH_DELAY, 1'b0, 1'b0};
				end else
					ph = '{LV_KEEP, LV_KEEP, PH_DELAY, 1'b0, 1'b1};
			end
			CMD_WACK: begin
				if (step == 5'd0)
					ph = '{LV_HIGH, LV_HIGH, PH_DELAY, 1'b0, 1'b0};
				else if (step == 5'd1)
					ph = '{LV_KEEP, LV_KEEP, PH_POLL, 1'b0, 1'b0};
				else
					ph = '{LV_LOW, LV_KEEP, PH_DELAY, 1'b0, 1'b1};
			end
			default: begin
				if (step == 5'd0)
					ph = '{LV_HIGH, LV_HIGH, PH_DELAY, 1'b0, 1'b0};
				else
					ph = '{LV_LOW, LV_HIGH, PH_TICK, 1'b0, 1'b1};
			end
		endcase
	end

endmodule

>>> rtl/i2cms_core.sv
// Sequencer state and the per-tick update of lines, counters and shift register.
module i2cms_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  i2cms_pkg::cfg_t   cfg,
	input  logic [2:0]        cmd,
	input  logic [7:0]        wr_byte,
	input  logic              sda_in,
	output i2cms_pkg::res_t   res
);
	import i2cms_pkg::*;

	logic [2:0] act_q;
	logic [4:0] step_q;
	logic [9:0] tick_q;
	logic [7:0] shift_q;
	logic [7:0] poll_q;
	logic       scl_q;
	logic       sda_q;
	logic       ack_q;

	logic       take;
	logic [2:0] act0;
	logic [4:0] step0;
	logic [4:0] step1;
	logic [9:0] tick0;
	logic [7:0] shift0;
	logic [7:0] poll0;
	logic       scl0;
	logic       sda0;
	logic       ack0;
	logic [9:0] tpd;

	logic [2:0] n_act;
	logic [4:0] n_step;
	logic [9:0] n_tick;
	logic [7:0] n_shift;
	logic [7:0] n_poll;
	logic       n_scl;
	logic       n_sda;
	logic       n_ack;
	logic       busy;
	logic       done;
	logic       ph_end;

	phase_t ph_ent;
	phase_t ph_cur;
	phase_t ph_nxt;

	function automatic logic lv_apply(input logic [1:0] code, input logic cur,
			input logic bitv);
		logic r;
		case (code)
			LV_LOW:  r = 1'b0;
			LV_HIGH: r = 1'b1;
			LV_BIT:  r = bitv;
			default: r = cur;
		endcase
		return r;
	endfunction

	// take a new command only while idle
	assign take  = (act_q == CMD_NONE) && (cmd >= CMD_START) && (cmd <= CMD_NACK);
	assign act0  = take ? cmd : act_q;
	assign step0 = take ? 5'd0 : step_q;
	assign step1 = step0 + 5'd1;
	assign poll0 = take ? 8'd0 : poll_q;
	assign shift0 = (take && cmd == CMD_WRITE) ? wr_byte : shift_q;
	assign ack0  = (take && cmd == CMD_WACK) ? 1'b0 : ack_q;
	assign tick0 = take ? 10'd0 : tick_q;
	assign scl0  = take ? lv_apply(ph_ent.scl, scl_q, shift0[7]) : scl_q;
	assign sda0  = take ? lv_apply(ph_ent.sda, sda_q, shift0[7]) : sda_q;
	assign tpd   = (cfg.ticks_per_delay == 10'd0) ? 10'd1 : cfg.ticks_per_delay;

	i2cms_phase u_ph_ent (.cmd(cmd),  .step(5'd0),  .ph(ph_ent));
	i2cms_phase u_ph_cur (.cmd(act0), .step(step0), .ph(ph_cur));
	i2cms_phase u_ph_nxt (.cmd(act0), .step(step1), .ph(ph_nxt));

	// advance the current phase by one tick
	always_comb begin
		n_act   = act0;
		n_step  = step0;
		n_tick  = tick0;
		n_shift = shift0;
		n_poll  = poll0;
		n_scl   = scl0;
		n_sda   = sda0;
		n_ack   = ack0;
		busy    = 1'b0;
		done    = 1'b0;
		ph_end  = 1'b0;
		if (act0 != CMD_NONE) begin
			busy = 1'b1;
			case (ph_cur.kind)
				PH_DELAY: begin
					if (({1'b0, tick0} + 11'd1) >= {1'b0, tpd})
						ph_end = 1'b1;
					else
						n_tick = tick0 + 10'd1;
				end
				PH_TICK: ph_end = 1'b1;
				default: begin
					if (!sda_in) begin
						n_ack  = 1'b1;
						ph_end = 1'b1;
					end else if (poll0 >= cfg.ack_poll_limit)
						ph_end = 1'b1;
					else
						n_poll = poll0 + 8'd1;
				end
			endcase
			if (ph_end) begin
				if (ph_cur.sample)
					n_shift = {shift0[6:0], sda_in};
				if (ph_cur.last) begin
					done   = 1'b1;
					n_act  = CMD_NONE;
					n_step = 5'd0;
					n_tick = 10'd0;
				end else begin
					n_step = step1;
					n_scl  = lv_apply(ph_nxt.scl, scl0, n_shift[7]);
					n_sda  = lv_apply(ph_nxt.sda, sda0, n_shift[7]);
					n_tick = 10'd0;
				end
			end
		end
	end

	assign res = '{scl: scl0, sda: sda0, busy: busy, done: done,
		rd_byte: n_shift, ack: n_ack};

	// hold state between accepted ticks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q   <= CMD_NONE;
			step_q  <= 5'd0;
			tick_q  <= 10'd0;
			shift_q <= 8'd0;
			poll_q  <= 8'd0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
			ack_q   <= 1'b0;
		end else if (accept) begin
			act_q   <= n_act;
			step_q  <= n_step;
			tick_q  <= n_tick;
			shift_q <= n_shift;
			poll_q  <= n_poll;
			scl_q   <= n_scl;
			sda_q   <= n_sda;
			ack_q   <= n_ack;
		end
	end

endmodule

>>> rtl/i2c_master_bit_sequencer.sv
// Top level of the I2C master bit sequencer: configuration, input handshake, result register.
//
// Each input transaction is one bus tick carrying cmd, wr_byte and the sampled
// sda_in. Every accepted tick yields exactly one result transaction with the
// SCL/SDA drive levels of that tick, busy/done flags, the shift register and
// the acknowledge flag.
// The result of a tick is registered and appears on out_valid in the cycle after it is
// accepted. Throughput: one tick per cycle while in_stall is low; the whole tick update
// is one pass of logic between the sequencer state and the result register.
// in_stall rises only while a result is held and out_stall is high; the
// result register then holds its contents and no tick is taken.
// Commands are taken only while idle; a command on a busy tick is ignored.
// Configuration: cfg_valid/cfg_ready with cfg_index (0 ticks_per_delay,
// 1 ack_poll_limit) and cfg_data; cfg_ready is always high. Write only while
// idle.
// Reset (arst_n low): idle, both lines released, counters and shift register
// cleared, ticks_per_delay 5, ack_poll_limit 255, no result pending.
module i2c_master_bit_sequencer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [2:0] cmd,
	input  logic [7:0] wr_byte,
	input  logic       sda_in,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       scl_drive,
	output logic       sda_drive,
	output logic       busy_res,
	output logic       done_res,
	output logic [7:0] rd_byte,
	output logic       ack_seen,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [9:0] cfg_data
);
	import i2cms_pkg::*;

	cfg_t cfg_q;
	res_t res;
	res_t res_q;
	logic out_valid_q;
	logic accept;

	assign cfg_ready = 1'b1;
	assign in_stall  = out_valid_q && out_stall;
	assign accept    = in_valid && !in_stall;

	// write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ticks_per_delay <= TPD_RESET;
			cfg_q.ack_poll_limit  <= POLL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_TPD:  cfg_q.ticks_per_delay <= cfg_data;
				CFG_POLL: cfg_q.ack_poll_limit  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	i2cms_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.cfg     (cfg_q),
		.cmd     (cmd),
		.wr_byte (wr_byte),
		.sda_in  (sda_in),
		.res     (res)
	);

	// hold result valid until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (accept)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	// load result payload on each accepted tick
	always_ff @(posedge clk) begin
		if (accept)
			res_q <= res;
	end

	assign out_valid = out_valid_q;
	assign scl_drive = res_q.scl;
	assign sda_drive = res_q.sda;
	assign busy_res  = res_q.busy;
	assign done_res  = res_q.done;
	assign rd_byte   = res_q.rd_byte;
	assign ack_seen  = res_q.ack;

endmodule

>>> rtl/i2cms_checker.sv
// Port-level checks of the I2C master bit sequencer, bound to the top level.
module i2cms_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic       busy_res,
	input logic       done_res,
	input logic [7:0] rd_byte
);

	// a finished sequence is always reported as busy
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> busy_res)
		else $error("done_res without busy_res");

	// input is stalled only while a result waits on a stalled output
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("in_stall without a held result");

	// every accepted tick leaves a result pending next cycle
	a_accept_res: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> out_valid)
		else $error("accepted tick produced no result");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(rd_byte) && $stable(done_res))
		else $error("stalled result changed");

endmodule

bind i2c_master_bit_sequencer i2cms_checker u_i2cms_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.busy_res  (busy_res),
	.done_res  (done_res),
	.rd_byte   (rd_byte)
);

>>> verif/tb_top.sv
// Self-checking testbench for the I2C master bit sequencer: tick driver, result monitor, predictor.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import i2cms_pkg::*;

	// reserved command code and the unused register slots
	localparam logic [2:0] CMD_RSVD    = 3'd7;
	localparam logic [1:0] CFG_SPARE_A = 2'd2;
	localparam logic [1:0] CFG_SPARE_B = 2'd3;

	// idle styles of either side
	localparam int IDLE_NONE  = 0;
	localparam int IDLE_SOME  = 1;
	localparam int IDLE_HEAVY = 2;

	// SDA fill of the ticks of one command
	localparam int SDA_RANDOM = 0;
	localparam int SDA_ONES   = 1;
	localparam int SDA_ZEROS  = 2;

	// acknowledge position that never comes
	localparam int NO_ACK = 1000;
	localparam int HOLD_CYCLES = 300;

	typedef struct {
		logic [2:0] cmd;
		logic [7:0] data;
		logic       sda;
	} bus_tick_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [2:0] cmd = CMD_NONE;
	logic [7:0] wr_byte = 8'h00;
	logic       sda_in = 1'b1;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic       scl_drive;
	logic       sda_drive;
	logic       busy_res;
	logic       done_res;
	logic [7:0] rd_byte;
	logic       ack_seen;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [1:0] cfg_index = CFG_TPD;
	logic [9:0] cfg_data = 10'd0;

	// bus sequencer image and its settings
	logic [9:0] tpd_cfg = TPD_RESET;
	logic [7:0] poll_cfg = POLL_RESET;
	logic [2:0] seq_cmd = CMD_NONE;
	logic [4:0] seq_step = 5'd0;
	logic [9:0] seq_ticks = 10'd0;
	logic [7:0] shift_q = 8'h00;
	logic [7:0] poll_q = 8'h00;
	logic       scl_q = 1'b1;
	logic       sda_q = 1'b1;
	logic       ack_q = 1'b0;

	bus_tick_t pending_ticks[$];
	res_t      expected_lines[$];

	int  tx_mode = IDLE_SOME;
	int  rx_mode = IDLE_SOME;
	int  tx_gap = 0;
	int  rx_gap = 0;
	bit  hold_request = 1'b0;
	logic rx_hold = 1'b0;

	int err_count = 0;
	int n_ticks = 0;
	int n_lines = 0;
	int n_seqs = 0;
	int n_acks = 0;
	int n_timeouts = 0;
	int n_writes = 0;

	i2c_master_bit_sequencer i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.wr_byte   (wr_byte),
		.sda_in    (sda_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.scl_drive (scl_drive),
		.sda_drive (sda_drive),
		.busy_res  (busy_res),
		.done_res  (done_res),
		.rd_byte   (rd_byte),
		.ack_seen  (ack_seen),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// line phase of a command at a given step
	function automatic phase_t bus_phase(input logic [2:0] c, input logic [4:0] s);
		phase_t p;
		p.scl = LV_KEEP;
		p.sda = LV_KEEP;
		p.kind = PH_DELAY;
		p.sample = 1'b0;
		p.last = 1'b0;
		case (c)
		CMD_START, CMD_STOP: begin
			if (s == 5'd0) begin
				p.scl = LV_HIGH;
				p.sda = (c == CMD_START) ? LV_HIGH : LV_LOW;
			end else if (s == 5'd1) begin
				p.sda = (c == CMD_START) ? LV_LOW : LV_HIGH;
			end else begin
				p.scl = LV_LOW;
				p.kind = PH_TICK;
				p.last = 1'b1;
			end
		end
		CMD_WRITE: begin
			if (s < WR_BIT_STEPS) begin
				case (s % 3)
				0: p.scl = LV_LOW;
				1: p.sda = LV_BIT;
				default: begin
					p.scl = LV_HIGH;
					p.sample = 1'b1;
				end
				endcase
			end else if (s == WR_BIT_STEPS) begin
				p.scl = LV_LOW;
			end else begin
				p.sda = LV_HIGH;
				p.last = 1'b1;
			end
		end
		CMD_READ: begin
			if (s == 5'd0) begin
				p.scl = LV_LOW;
			end else if (s <= RD_BIT_LAST) begin
				if (s[0]) begin
					p.scl = LV_HIGH;
					p.sda = LV_HIGH;
					p.sample = 1'b1;
				end else begin
					p.scl = LV_LOW;
				end
			end else begin
				p.last = 1'b1;
			end
		end
		CMD_WACK: begin
			if (s == 5'd0) begin
				p.scl = LV_HIGH;
				p.sda = LV_HIGH;
			end else if (s == 5'd1) begin
				p.kind = PH_POLL;
			end else begin
				p.scl = LV_LOW;
				p.last = 1'b1;
			end
		end
		default: begin
			p.scl = (s == 5'd0) ? LV_HIGH : LV_LOW;
			p.sda = LV_HIGH;
			if (s != 5'd0) begin
				p.kind = PH_TICK;
				p.last = 1'b1;
			end
		end
		endcase
		return p;
	endfunction

	// set the lines for the phase just entered
	task automatic load_phase();
		phase_t p;
		p = bus_phase(seq_cmd, seq_step);
		if (p.scl != LV_KEEP) scl_q = p.scl[0];
		if (p.sda == LV_BIT) sda_q = shift_q[7];
		else if (p.sda != LV_KEEP) sda_q = p.sda[0];
		seq_ticks = 10'd0;
	endtask

	// advance the sequencer by one bus tick and form the line levels of that tick
	task automatic step_sequencer(input logic [2:0] c, input logic [7:0] b, input logic sd,
			output res_t r);
		phase_t p;
		logic [9:0] tpd_eff;
		logic fin;
		if (seq_cmd == CMD_NONE && c >= CMD_START && c <= CMD_NACK) begin
			seq_cmd = c;
			seq_step = 5'd0;
			poll_q = 8'h00;
			n_seqs++;
			if (c == CMD_WRITE) shift_q = b;
			if (c == CMD_WACK) ack_q = 1'b0;
			load_phase();
		end
		r.scl = scl_q;
		r.sda = sda_q;
		r.busy = 1'b0;
		r.done = 1'b0;
		if (seq_cmd != CMD_NONE) begin
			p = bus_phase(seq_cmd, seq_step);
			tpd_eff = (tpd_cfg == 10'd0) ? 10'd1 : tpd_cfg;
			fin = 1'b0;
			r.busy = 1'b1;
			case (p.kind)
			PH_DELAY: begin
				if (int'(seq_ticks) + 1 >= int'(tpd_eff)) fin = 1'b1;
				else seq_ticks = seq_ticks + 10'd1;
			end
			PH_TICK: fin = 1'b1;
			PH_POLL: begin
				if (!sd) begin
					ack_q = 1'b1;
					fin = 1'b1;
					n_acks++;
				end else if (poll_q >= poll_cfg) begin
					fin = 1'b1;
					n_timeouts++;
				end else begin
					poll_q = poll_q + 8'd1;
				end
			end
			default: fin = 1'b0;
			endcase
			if (fin) begin
				if (p.sample) shift_q = {shift_q[6:0], sd};
				if (p.last) begin
					r.done = 1'b1;
					seq_cmd = CMD_NONE;
					seq_step = 5'd0;
					seq_ticks = 10'd0;
				end else begin
					seq_step = seq_step + 5'd1;
					load_phase();
				end
			end
		end
		r.rd_byte = shift_q;
		r.ack = ack_q;
	endtask

	function automatic int draw_gap(input int mode);
		case (mode)
		IDLE_NONE: return 0;
		IDLE_SOME: return ($urandom_range(0, 4) == 0) ? $urandom_range(1, 14) : 0;
		default: return $urandom_range(0, 14);
		endcase
	endfunction

	// where in a poll the slave answers
	function automatic int draw_ack();
		case ($urandom_range(0, 7))
		0, 1, 2, 3: return 0;
		4, 5: return $urandom_range(1, 8);
		6: return $urandom_range(9, 300);
		default: return NO_ACK;
		endcase
	endfunction

	task automatic flag_error(input string msg);
		err_count++;
		if (err_count <= 10) $display("%s", msg);
	endtask

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (want !== got)
			flag_error($sformatf("result %0d: %s expected %0h, got %0h", n_lines, name, want, got));
	endtask

	// queue a command tick followed by the ticks that play it out
	task automatic queue_command(input logic [2:0] c, input logic [7:0] b, input int ack_at,
			input int sda_mode);
		bus_tick_t t;
		int eff;
		int len;
		int poll_len;
		eff = (tpd_cfg == 10'd0) ? 1 : int'(tpd_cfg);
		poll_len = (ack_at <= int'(poll_cfg)) ? ack_at + 1 : int'(poll_cfg) + 1;
		case (c)
		CMD_START, CMD_STOP: len = 2 * eff + 1;
		CMD_WRITE: len = (int'(WR_BIT_STEPS) + 2) * eff;
		CMD_READ: len = (int'(RD_BIT_LAST) + 2) * eff;
		CMD_WACK: len = 2 * eff + poll_len;
		CMD_NACK: len = eff + 1;
		default: len = 1;
		endcase
		for (int k = 0; k < len; k++) begin
			// commands on busy ticks must be ignored
			if (k == 0) t.cmd = c;
			else t.cmd = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(1, 7)) : CMD_NONE;
			t.data = (k == 0) ? b : 8'($urandom);
			case (sda_mode)
			SDA_ONES: t.sda = 1'b1;
			SDA_ZEROS: t.sda = 1'b0;
			default: t.sda = 1'($urandom);
			endcase
			if (c == CMD_WACK && k >= eff && k < eff + poll_len)
				t.sda = !(k == eff + poll_len - 1 && ack_at <= int'(poll_cfg));
			pending_ticks.push_back(t);
		end
	endtask

	// one bus transaction: mostly well formed, sometimes commands in any order
	task automatic queue_transfer();
		int n;
		if ($urandom_range(0, 7) == 0) begin
			n = $urandom_range(1, 4);
			repeat (n) queue_command(3'($urandom_range(0, 7)), 8'($urandom), draw_ack(), SDA_RANDOM);
		end else begin
			queue_command(CMD_START, 8'($urandom), NO_ACK, SDA_RANDOM);
			queue_command(CMD_WRITE, 8'($urandom), NO_ACK, SDA_RANDOM);
			queue_command(CMD_WACK, 8'($urandom), draw_ack(), SDA_RANDOM);
			n = $urandom_range(1, 3);
			repeat (n) begin
				if ($urandom_range(0, 1) == 0) begin
					queue_command(CMD_WRITE, 8'($urandom), NO_ACK, SDA_RANDOM);
					queue_command(CMD_WACK, 8'($urandom), draw_ack(), SDA_RANDOM);
				end else begin
					queue_command(CMD_READ, 8'($urandom), NO_ACK, SDA_RANDOM);
					if ($urandom_range(0, 1) == 0)
						queue_command(CMD_NACK, 8'($urandom), NO_ACK, SDA_RANDOM);
					else
						queue_command(CMD_WACK, 8'($urandom), draw_ack(), SDA_RANDOM);
				end
			end
			queue_command(CMD_STOP, 8'($urandom), NO_ACK, SDA_RANDOM);
		end
		// idle ticks between transactions
		n = $urandom_range(0, 2);
		repeat (n) begin
			queue_command(($urandom_range(0, 3) == 0) ? CMD_RSVD : CMD_NONE, 8'($urandom), NO_ACK,
				SDA_RANDOM);
		end
	endtask

	// wait for every result, padding with idle ticks until the sequencer is idle
	task automatic settle();
		forever begin
			do @(negedge clk);
			while (pending_ticks.size() != 0 || in_valid || expected_lines.size() != 0);
			if (seq_cmd == CMD_NONE) break;
			repeat (8) queue_command(CMD_NONE, 8'h00, NO_ACK, SDA_RANDOM);
		end
		repeat (2) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [9:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		n_writes++;
		if (idx == CFG_TPD) tpd_cfg = data;
		else if (idx == CFG_POLL) poll_cfg = data[7:0];
	endtask

	task automatic run_phase(input logic [9:0] tpd, input logic [9:0] poll, input int tx,
			input int rx, input int n_items, input bit hold);
		int start;
		write_reg(CFG_TPD, tpd);
		write_reg(CFG_POLL, poll);
		tx_mode = tx;
		rx_mode = rx;
		start = pending_ticks.size();
		while (pending_ticks.size() - start < n_items) queue_transfer();
		// stall the results while the sender keeps streaming
		if (hold) begin
			@(negedge clk);
			hold_request = 1'b1;
		end
		settle();
	endtask

	// tick driver: hold a stalled transaction, otherwise offer the next one after its gap
	always @(posedge clk) begin
		res_t line;
		bus_tick_t nt;
		if (in_valid && !in_stall) begin
			step_sequencer(cmd, wr_byte, sda_in, line);
			expected_lines.push_back(line);
			n_ticks++;
			tx_gap = draw_gap(tx_mode);
		end
		if (!(in_valid && in_stall)) begin
			if (!arst_n || tx_gap != 0 || pending_ticks.size() == 0) begin
				if (tx_gap != 0) tx_gap--;
				in_valid <= 1'b0;
			end else begin
				nt = pending_ticks.pop_front();
				in_valid <= 1'b1;
				cmd <= nt.cmd;
				wr_byte <= nt.data;
				sda_in <= nt.sda;
			end
		end
	end

	// result monitor: compare against the oldest expectation, then draw the next stall
	always @(posedge clk) begin
		res_t want;
		bit stall_now;
		if (out_valid && !out_stall) begin
			n_lines++;
			if (expected_lines.size() == 0) begin
				flag_error($sformatf("result %0d arrived with nothing expected", n_lines));
			end else begin
				want = expected_lines.pop_front();
				check_field("scl_drive", want.scl, scl_drive);
				check_field("sda_drive", want.sda, sda_drive);
				check_field("busy_res", want.busy, busy_res);
				check_field("done_res", want.done, done_res);
				check_field("rd_byte", want.rd_byte, rd_byte);
				check_field("ack_seen", want.ack, ack_seen);
			end
			rx_gap = draw_gap(rx_mode);
		end
		stall_now = (rx_gap != 0);
		if (stall_now) rx_gap--;
		out_stall <= rx_hold || stall_now;
	end

	// long receiver hold-off, counted here
	always begin
		wait (hold_request);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold <= 1'b0;
		hold_request = 1'b0;
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset settings, every command, byte extremes, poll timeout at full limit
		queue_command(CMD_NONE, 8'h00, NO_ACK, SDA_RANDOM);
		queue_command(CMD_START, 8'h5A, NO_ACK, SDA_RANDOM);
		queue_command(CMD_WRITE, 8'hFF, NO_ACK, SDA_ONES);
		queue_command(CMD_WACK, 8'h00, 0, SDA_RANDOM);
		queue_command(CMD_WRITE, 8'h00, NO_ACK, SDA_ZEROS);
		queue_command(CMD_WACK, 8'hFF, NO_ACK, SDA_RANDOM);
		queue_command(CMD_WACK, 8'h3C, 40, SDA_RANDOM);
		queue_command(CMD_READ, 8'h00, NO_ACK, SDA_ONES);
		queue_command(CMD_READ, 8'hFF, NO_ACK, SDA_ZEROS);
		queue_command(CMD_NACK, 8'hA5, NO_ACK, SDA_RANDOM);
		queue_command(CMD_RSVD, 8'h81, NO_ACK, SDA_RANDOM);
		queue_command(CMD_STOP, 8'h7E, NO_ACK, SDA_RANDOM);
		settle();

		// random traffic over several bus settings
		run_phase(10'd1, 10'd3, IDLE_HEAVY, IDLE_HEAVY, 100, 1'b0);
		run_phase(10'd0, 10'd0, IDLE_NONE, IDLE_NONE, 80, 1'b1);
		run_phase(10'd2, 10'h3FF, IDLE_SOME, IDLE_HEAVY, 120, 1'b0);
		write_reg(CFG_SPARE_A, 10'($urandom));
		write_reg(CFG_SPARE_B, 10'($urandom));
		run_phase(10'd3, 10'd17, IDLE_HEAVY, IDLE_SOME, 100, 1'b0);

		// slow bus: a short sequence only
		write_reg(CFG_TPD, 10'd64);
		write_reg(CFG_POLL, 10'd1);
		tx_mode = IDLE_NONE;
		rx_mode = IDLE_NONE;
		queue_command(CMD_START, 8'($urandom), NO_ACK, SDA_RANDOM);
		queue_command(CMD_NACK, 8'($urandom), NO_ACK, SDA_RANDOM);
		queue_command(CMD_STOP, 8'($urandom), NO_ACK, SDA_RANDOM);
		settle();

		run_phase(10'd1, 10'd255, IDLE_HEAVY, IDLE_HEAVY, 100, 1'b0);

		$display("Covered %0d bus ticks, %0d command sequences, %0d register writes",
			n_ticks, n_seqs, n_writes);
		$display("Acknowledge waits: %0d answered, %0d timed out; %0d mismatches",
			n_acks, n_timeouts, err_count);
		if (err_count == 0 && expected_lines.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// run limit
	initial begin
		#6_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
